@@ rtl/brl_pkg.sv @@
package brl_pkg;

   // Coordinate width of the framebuffer grid.
   localparam int COORD_BITS = 6;
   localparam int DIM_BITS   = 7;
   localparam int CHAR_BITS  = 16;
   localparam int ERR_BITS   = COORD_BITS + 3;
   localparam int ERR_LIM    = 2 * ((1 << COORD_BITS) - 1);

   localparam int REQ_FIELD_BITS = 4 * COORD_BITS + 2 * CHAR_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 2 * COORD_BITS + 2 * CHAR_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // Register indexes of the configuration port.
   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_HEIGHT = 1'd1;

   localparam logic [DIM_BITS-1:0] SCREEN_WIDTH_RST  = 7'd64;
   localparam logic [DIM_BITS-1:0] SCREEN_HEIGHT_RST = 7'd30;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RUN
   } brl_state_type;

   typedef struct packed {
      logic load;   // latch the command word
      logic setup;  // derive deltas and error term
      logic emit;   // push one pixel word and advance the walker
   } brl_cmd_type;

   typedef struct packed {
      logic out_free;     // output register can take a word this cycle
      logic final_pixel;  // walker sits on the last pixel of the line
   } brl_sts_type;

endpackage

@@ rtl/brl_ctrl.sv @@
module brl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  brl_pkg::brl_sts_type sts,
   output brl_pkg::brl_cmd_type cmd
);
   import brl_pkg::*;

   brl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.setup = 1'b1;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.final_pixel) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Only one command at a time, and never a new word taken mid-line.
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.setup, cmd.emit}))
      else $error("controller issued overlapping commands");

   a_setup_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.setup)
      else $error("setup did not follow a command load");

   a_no_accept_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> !req_tready)
      else $error("command accepted while a line is being walked");

endmodule

@@ rtl/brl_datapath.sv @@
module brl_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [brl_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   input  logic                                  csr_we,
   input  logic [brl_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [brl_pkg::DIM_BITS-1:0]          csr_wdata,
   input  brl_pkg::brl_cmd_type                  cmd,
   output brl_pkg::brl_sts_type                  sts,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [brl_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   output logic                                  rsp_tlast,
   output logic                                  rsp_tuser
);
   import brl_pkg::*;

   localparam int C = COORD_BITS;
   localparam int E = ERR_BITS;

   // Screen size registers.
   logic [DIM_BITS-1:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SCREEN_WIDTH_RST;
         height_ff <= SCREEN_HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata;
            CSR_SCREEN_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Latched command word.
   logic [C-1:0]         sx_ff, sy_ff, ex_ff, ey_ff;
   logic [CHAR_BITS-1:0] glyph_ff, colour_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sx_ff     <= req_tdata[C-1:0];
         sy_ff     <= req_tdata[2*C-1:C];
         ex_ff     <= req_tdata[3*C-1:2*C];
         ey_ff     <= req_tdata[4*C-1:3*C];
         glyph_ff  <= req_tdata[4*C+CHAR_BITS-1:4*C];
         colour_ff <= req_tdata[4*C+2*CHAR_BITS-1:4*C+CHAR_BITS];
      end
   end

   // Setup: deltas, major axis, start point, error term.
   logic signed [C:0] dx, dy;
   logic [C-1:0]      adx, ady, major, minor, x0, y0;
   logic              xmaj, step_neg;
   logic signed [E-1:0] err_init, inc_hold, inc_step;

   always_comb begin
      dx   = $signed({1'b0, ex_ff}) - $signed({1'b0, sx_ff});
      dy   = $signed({1'b0, ey_ff}) - $signed({1'b0, sy_ff});
      adx  = dx[C] ? C'(-dx) : dx[C-1:0];
      ady  = dy[C] ? C'(-dy) : dy[C-1:0];
      xmaj = (ady <= adx);
      step_neg = !((dx[C] && dy[C]) ||
                   (!dx[C] && (dx != '0) && !dy[C] && (dy != '0)));
      major = xmaj ? adx : ady;
      minor = xmaj ? ady : adx;
      if (xmaj ? dx[C] : dy[C]) begin
         x0 = ex_ff;
         y0 = ey_ff;
      end else begin
         x0 = sx_ff;
         y0 = sy_ff;
      end
      err_init = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
      inc_hold = $signed({2'b00, minor, 1'b0});
      inc_step = $signed({2'b00, minor, 1'b0}) - $signed({2'b00, major, 1'b0});
   end

   // Walker state.
   logic [C-1:0]        x_ff, y_ff, cnt_ff;
   logic                xmaj_ff, step_neg_ff;
   logic signed [E-1:0] err_ff, hold_ff, step_ff;
   logic [C-1:0]        x_in, y_in, minor_step;
   logic signed [E-1:0] err_in;
   logic                hold;

   always_comb begin
      hold       = xmaj_ff ? err_ff[E-1] : (err_ff[E-1] || (err_ff == '0));
      minor_step = step_neg_ff ? {C{1'b1}} : C'(1);
      err_in     = err_ff + (hold ? hold_ff : step_ff);
      if (xmaj_ff) begin
         x_in = x_ff + C'(1);
         y_in = hold ? y_ff : y_ff + minor_step;
      end else begin
         y_in = y_ff + C'(1);
         x_in = hold ? x_ff : x_ff + minor_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         x_ff        <= x0;
         y_ff        <= y0;
         cnt_ff      <= major;
         xmaj_ff     <= xmaj;
         step_neg_ff <= step_neg;
         err_ff      <= err_init;
         hold_ff     <= inc_hold;
         step_ff     <= inc_step;
      end else if (cmd.emit) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         cnt_ff <= cnt_ff - C'(1);
         err_ff <= err_in;
      end
   end

   // Output register.
   logic                 rsp_valid_ff;
   logic [C-1:0]         px_ff, py_ff;
   logic [CHAR_BITS-1:0] pg_ff, pc_ff;
   logic                 vis_ff, last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         px_ff   <= x_ff;
         py_ff   <= y_ff;
         pg_ff   <= glyph_ff;
         pc_ff   <= colour_ff;
         vis_ff  <= ({1'b0, x_ff} < width_ff) && ({1'b0, y_ff} < height_ff);
         last_ff <= (cnt_ff == '0);
      end
   end

   assign sts.out_free    = !rsp_valid_ff || rsp_tready;
   assign sts.final_pixel = (cnt_ff == '0);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({pc_ff, pg_ff, py_ff, px_ff});
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = vis_ff;

   a_cnt_down: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && !sts.final_pixel) |=> (cnt_ff == $past(cnt_ff) - C'(1)))
      else $error("pixel count did not step down");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (rsp_tvalid && (rsp_tlast == $past(sts.final_pixel))))
      else $error("last flag does not match the pixel count");

   a_err_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> ((err_ff <= E'(ERR_LIM)) && (err_ff >= -E'(ERR_LIM))))
      else $error("error term left its bound");

endmodule

@@ rtl/bresenham_line_rasterizer_unit.sv @@
// Bresenham line rasterizer. Each command word on the req_ channel carries two
// endpoints, a glyph code and a colour word; the block answers on the rsp_
// channel with one pixel write word per pixel of the integer Bresenham line,
// walked along the major axis from the endpoint with the smaller major-axis
// coordinate. rsp_tlast marks the final pixel of a line and rsp_tuser is the
// visible flag (pixel inside the programmed screen width and height); off-
// screen pixels are still emitted with the flag low. A line with a major-axis
// delta of n produces n+1 words. After acceptance the block latches the command,
// then sets up the deltas and error term, then emits one word per cycle from the
// single add-and-test error loop while rsp_tready does not stall it. The next
// command is accepted as soon as the last word of a line sits in the output
// register. Stalls on rsp_tready hold the walker. Program screen_width
// (index 0) and screen_height (index 1) only while the block is idle.
module bresenham_line_rasterizer_unit (
   input  logic                              clock,
   input  logic                              reset,
   // start_x, start_y, end_x, end_y, glyph, colour (lowest bits first)
   input  logic [brl_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pixel_x, pixel_y, pixel_glyph, pixel_colour (lowest bits first)
   output logic [brl_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // visible
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [brl_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [brl_pkg::DIM_BITS-1:0]      csr_wdata
);
   import brl_pkg::*;

   brl_cmd_type cmd;
   brl_sts_type sts;

   // Sequence accept, setup and the per-pixel advance.
   brl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Hold the command, walk the line and drive the output register.
   brl_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
